### hw/rtl/fpalu_pkg.sv
// Package for the fixed-point ALU: command codes and the payload types of
// the input and result channels. No dependencies.
package fpalu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_TO_INT   = 4'd14,
        CMD_FROM_INT = 4'd15
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               overflowed;
        logic               divide_by_zero;
    } t_out_item;

endpackage

### hw/rtl/fixed_point_alu_unit.sv
// Top level of the pipelined fixed-point ALU: decode, multiply, restoring
// divider with one quotient bit per stage, rounding and output register.
// Depends on fpalu_pkg.
//
// Every command runs through stages 1 to 3, the divider stages and the output
// register; throughput one item per cycle while the output does not stall.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Each stage moves on whenever the stage after it is empty or moving, so
// bubbles are squeezed out while the output waits.
// Reset (synchronous, active low) clears all valid bits; no data is reset.
module fixed_point_alu_unit #(
    parameter int FRACTION_BITS = 8,
    parameter int WORD_BITS     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fpalu_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fpalu_pkg::t_out_item o_out_data
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int NB = W + F;          // dividend and quotient width
    localparam int QM = 2 * W - F + 1;  // rounded product magnitude width

    typedef struct packed {
        fpalu_pkg::t_cmd   cmd;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
    } t_s1;

    typedef struct packed {
        fpalu_pkg::t_cmd cmd;
        logic [W-1:0]    res;
        logic            cmp;
        logic            ovf;
        logic            dz;
        logic            neg;
        logic [W-1:0]    ma;
        logic [W-1:0]    mb;
    } t_s2;

    typedef struct packed {
        t_s2            item;
        logic [2*W-1:0] prod;
    } t_s3;

    typedef struct packed {
        fpalu_pkg::t_cmd cmd;
        logic [W-1:0]    res;
        logic            cmp;
        logic            ovf;
        logic            dz;
        logic            neg;
        logic [W-1:0]    d;
        logic [NB-1:0]   nq;   // dividend bits shift out, quotient bits shift in
        logic [W-1:0]    rem;
    } t_dv;

    logic      r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    t_s1       r_s1;
    t_s2       r_s2, n_s2;
    t_s3       r_s3;
    t_dv       n_dv0;
    t_dv       r_dv     [NB+1];
    logic      r_dv_vld [NB+1];
    logic      w_dv_rdy [NB+1];
    logic      w_rdy_out, w_rdy_s3, w_rdy_s2, w_rdy_s1;
    fpalu_pkg::t_out_item r_out, n_out;

    // Ready ripples back from the output; a stage loads whenever its
    // successor can take what it holds.
    assign w_rdy_out = !r_out_vld || i_out_ready;
    assign w_dv_rdy[NB] = !r_dv_vld[NB] || w_rdy_out;
    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_rdy
            assign w_dv_rdy[g] = !r_dv_vld[g] || w_dv_rdy[g+1];
        end
    endgenerate
    assign w_rdy_s3 = !r_s3_vld || w_dv_rdy[0];
    assign w_rdy_s2 = !r_s2_vld || w_rdy_s3;
    assign w_rdy_s1 = !r_s1_vld || w_rdy_s2;
    assign o_in_ready = w_rdy_s1;

    // Stage 1: capture the operands at the word width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_rdy_s1) begin
            r_s1_vld <= i_in_valid;
        end
        if (w_rdy_s1) begin
            r_s1.cmd <= i_in_data.command;
            r_s1.a   <= i_in_data.operand_a[W-1:0];
            r_s1.b   <= i_in_data.operand_b[W-1:0];
        end
    end

    // Stage 1 to 2: every operation but multiply and divide, magnitudes and signs.
    always_comb begin
        logic [W:0]     sum;
        logic [W+F-1:0] ext;
        logic [F:0]     top;
        n_s2     = '0;
        n_s2.cmd = r_s1.cmd;
        n_s2.neg = r_s1.a[W-1] ^ r_s1.b[W-1];
        n_s2.ma  = r_s1.a[W-1] ? (~r_s1.a + 1'b1) : r_s1.a;
        n_s2.mb  = r_s1.b[W-1] ? (~r_s1.b + 1'b1) : r_s1.b;
        sum = '0;
        ext = {{F{r_s1.a[W-1]}}, r_s1.a} << F;
        top = ext[W+F-1:W-1];
        unique case (r_s1.cmd)
            fpalu_pkg::CMD_ADD: begin
                sum = {r_s1.a[W-1], r_s1.a} + {r_s1.b[W-1], r_s1.b};
                n_s2.res = sum[W-1:0];
                n_s2.ovf = sum[W] ^ sum[W-1];
            end
            fpalu_pkg::CMD_SUB: begin
                sum = {r_s1.a[W-1], r_s1.a} - {r_s1.b[W-1], r_s1.b};
                n_s2.res = sum[W-1:0];
                n_s2.ovf = sum[W] ^ sum[W-1];
            end
            fpalu_pkg::CMD_MUL: begin
            end
            fpalu_pkg::CMD_DIV: n_s2.dz = (r_s1.b == '0);
            fpalu_pkg::CMD_GT:  n_s2.cmp = r_s1.a > r_s1.b;
            fpalu_pkg::CMD_LT:  n_s2.cmp = r_s1.a < r_s1.b;
            fpalu_pkg::CMD_GE:  n_s2.cmp = r_s1.a >= r_s1.b;
            fpalu_pkg::CMD_LE:  n_s2.cmp = r_s1.a <= r_s1.b;
            fpalu_pkg::CMD_EQ:  n_s2.cmp = r_s1.a == r_s1.b;
            fpalu_pkg::CMD_NE:  n_s2.cmp = r_s1.a != r_s1.b;
            fpalu_pkg::CMD_MIN: n_s2.res = (r_s1.a < r_s1.b) ? r_s1.a : r_s1.b;
            fpalu_pkg::CMD_MAX: n_s2.res = (r_s1.a > r_s1.b) ? r_s1.a : r_s1.b;
            fpalu_pkg::CMD_INC: begin
                sum = {r_s1.a[W-1], r_s1.a} + (W+1)'(1);
                n_s2.res = sum[W-1:0];
                n_s2.ovf = sum[W] ^ sum[W-1];
            end
            fpalu_pkg::CMD_DEC: begin
                sum = {r_s1.a[W-1], r_s1.a} - (W+1)'(1);
                n_s2.res = sum[W-1:0];
                n_s2.ovf = sum[W] ^ sum[W-1];
            end
            fpalu_pkg::CMD_TO_INT: n_s2.res = r_s1.a >>> F;
            fpalu_pkg::CMD_FROM_INT: begin
                n_s2.res = ext[W-1:0];
                n_s2.ovf = !((&top) || !(|top));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_rdy_s2) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_rdy_s2) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 2 to 3: magnitude product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_rdy_s3) begin
            r_s3_vld <= r_s2_vld;
        end
        if (w_rdy_s3) begin
            r_s3.item <= r_s2;
            r_s3.prod <= r_s2.ma * r_s2.mb;
        end
    end

    // Stage 3 to divider entry: round the product, sign and wrap it, and
    // load the dividend |a| * 2^F for the divider.
    always_comb begin
        logic [2*W:0]  rnd;
        logic [QM-1:0] q;
        logic [W-1:0]  ql;
        rnd = {1'b0, r_s3.prod} + ((2*W+1)'(1) << (F - 1));
        q   = rnd[2*W:F];
        ql  = q[W-1:0];
        n_dv0.cmd = r_s3.item.cmd;
        n_dv0.res = r_s3.item.res;
        n_dv0.cmp = r_s3.item.cmp;
        n_dv0.ovf = r_s3.item.ovf;
        n_dv0.dz  = r_s3.item.dz;
        n_dv0.neg = r_s3.item.neg;
        n_dv0.d   = r_s3.item.mb;
        n_dv0.nq  = {r_s3.item.ma, {F{1'b0}}};
        n_dv0.rem = '0;
        if (r_s3.item.cmd == fpalu_pkg::CMD_MUL) begin
            n_dv0.res = r_s3.item.neg ? (~ql + 1'b1) : ql;
            n_dv0.ovf = r_s3.item.neg ? (q > (QM'(1) << (W - 1)))
                                      : (q > ((QM'(1) << (W - 1)) - QM'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_dv_rdy[0]) begin
            r_dv_vld[0] <= r_s3_vld;
        end
        if (w_dv_rdy[0]) begin
            r_dv[0] <= n_dv0;
        end
    end

    // Restoring divider: one quotient bit per stage.
    generate
        for (g = 1; g <= NB; g++) begin : g_div
            t_dv  n_st;
            logic [W:0] tmp;
            logic       ge;
            always_comb begin
                n_st = r_dv[g-1];
                tmp  = {r_dv[g-1].rem, r_dv[g-1].nq[NB-1]};
                ge   = tmp >= {1'b0, r_dv[g-1].d};
                n_st.rem = ge ? W'(tmp - {1'b0, r_dv[g-1].d}) : tmp[W-1:0];
                n_st.nq  = {r_dv[g-1].nq[NB-2:0], ge};
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[g] <= 1'b0;
                end else if (w_dv_rdy[g]) begin
                    r_dv_vld[g] <= r_dv_vld[g-1];
                end
                if (w_dv_rdy[g]) begin
                    r_dv[g] <= n_st;
                end
            end
        end
    endgenerate

    // Final stage: for a division with a nonzero divisor, round the quotient half away from zero, sign and wrap.
    always_comb begin
        logic [NB:0]  qr;
        logic         up;
        logic [W-1:0] res;
        logic         ovf;
        up  = {r_dv[NB].rem, 1'b0} >= {1'b0, r_dv[NB].d};
        qr  = {1'b0, r_dv[NB].nq} + (NB+1)'(up);
        res = r_dv[NB].res;
        ovf = r_dv[NB].ovf;
        if (r_dv[NB].cmd == fpalu_pkg::CMD_DIV && !r_dv[NB].dz) begin
            res = r_dv[NB].neg ? (~qr[W-1:0] + 1'b1) : qr[W-1:0];
            ovf = r_dv[NB].neg ? (qr > ((NB+1)'(1) << (W - 1)))
                               : (qr > (((NB+1)'(1) << (W - 1)) - (NB+1)'(1)));
        end
        n_out.result_value   = 32'(signed'(res));
        n_out.compare_true   = r_dv[NB].cmp;
        n_out.overflowed     = ovf;
        n_out.divide_by_zero = r_dv[NB].dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_vld <= r_dv_vld[NB];
        end
        if (w_rdy_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A division by zero must come out as zero with no overflow.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_by_zero |->
            o_out_data.result_value == 32'sd0 && !o_out_data.overflowed)
        else $error("divide by zero result not cleared");

    // A comparison carries its outcome only in the flag.
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.compare_true |->
            o_out_data.result_value == 32'sd0 && !o_out_data.overflowed
            && !o_out_data.divide_by_zero)
        else $error("comparison result carries stray value");

    // Input back-pressure only arises when a finished result is held.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

endmodule
